@@ rtl/bom_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// bom_pkg: shared widths, table layouts and constants for blob_orientation_moments
// depends on nothing

package bom_pkg;

    localparam int MAX_BLOBS_DEF  = 64;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int IDX_W   = 6;
    localparam int COORD_W = 12;
    localparam int COV_W   = 50;
    localparam int VAR_W   = 49;
    localparam int DIST_W  = 26;
    localparam int CORD_W  = 53;
    localparam int ZW      = 20;
    localparam int SQ_W    = 36;
    localparam int ANGLE_W = 16;
    localparam int LEN_W   = 18;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic signed [ZW-1:0]      HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;

    typedef struct packed {
        logic [IDX_W-1:0]   assign_idx;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
    } ent_t;

    typedef struct packed {
        logic [DIST_W-1:0] maxd;
        logic [VAR_W-1:0]  vy;
        logic [VAR_W-1:0]  vx;
        logic [COV_W-1:0]  cov;
    } acc_t;

    function automatic logic signed [ZW-1:0] atan_q16(input logic [3:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            4'd15:   v = 20'sd2;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/blob_orientation_moments.sv @@
`timescale 1ns / 1ps
`default_nettype none
// blob_orientation_moments: blob table with second-moment accumulators and orientation query
// depends on bom_pkg

// One word is handled at a time. A load writes its entry as it is accepted; a pixel passes
// through label entry read, blob entry and accumulator read, multiply, one pipeline stage
// and write back. A query on a blob that is unavailable or out of range goes straight to
// its output step; else it passes through accept, read, normalizing, CORDIC, square root
// and output, the normalizing shift moving one bit a cycle. A blob with both variances
// zero skips normalizing and CORDIC. A result word waits in the output register while
// the next word is taken; a further query holds in its output state until that register
// is free.
module blob_orientation_moments #(
    parameter int MAX_BLOBS  = bom_pkg::MAX_BLOBS_DEF,
    parameter int MAX_WIDTH  = bom_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bom_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // blob_index, centroid_x, centroid_y, assignment, available, pixel_x, pixel_y,
    // label, label_present, zero pad
    input  wire logic [71:0] s_tdata,
    // command
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // result_index, angle, length
    output logic [39:0]      m_tdata,
    // result_valid, degenerate
    output logic [1:0]       m_tuser
);

    localparam int AW = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
    localparam int CW = bom_pkg::CORD_W;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_PENT   = 10'b0000000010,
        ST_PCEN   = 10'b0000000100,
        ST_PWB    = 10'b0000001000,
        ST_QRD    = 10'b0000010000,
        ST_QNORM  = 10'b0000100000,
        ST_QCORD  = 10'b0001000000,
        ST_QSQRT  = 10'b0010000000,
        ST_QOUT   = 10'b0100000000,
        ST_PMUL   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // input fields
    logic [1:0]  in_cmd;
    logic [5:0]  in_bi, in_assign, in_label;
    logic [11:0] in_cx, in_cy, in_px, in_py;
    logic        in_avail, in_lp;
    assign in_cmd    = s_tuser;
    assign in_bi     = s_tdata[5:0];
    assign in_cx     = s_tdata[17:6];
    assign in_cy     = s_tdata[29:18];
    assign in_assign = s_tdata[35:30];
    assign in_avail  = s_tdata[36];
    assign in_px     = s_tdata[48:37];
    assign in_py     = s_tdata[60:49];
    assign in_label  = s_tdata[66:61];
    assign in_lp     = s_tdata[67];

    // memories
    bom_pkg::ent_t ent_mem [MAX_BLOBS];
    bom_pkg::acc_t acc_mem [MAX_BLOBS];
    bom_pkg::ent_t ent_rd_reg, ent_wd;
    bom_pkg::acc_t acc_rd_reg, acc_wd;
    logic          ent_we, ent_re, acc_we, acc_re;
    logic [AW-1:0] ent_wa, ent_ra, acc_ra;

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (ent_re) begin
            ent_rd_reg <= ent_mem[ent_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_ra] <= acc_wd;
        end
        if (acc_re) begin
            acc_rd_reg <= acc_mem[acc_ra];
        end
    end

    logic [MAX_BLOBS-1:0] avail_reg, acc_vld_reg;

    // datapath registers
    logic [AW-1:0]               addr_reg;
    logic [11:0]                 px_reg, py_reg;
    logic signed [25:0]          pxy_reg, pxx_reg, pyy_reg;
    logic signed [CW-1:0]        x_reg, y_reg;
    logic signed [bom_pkg::ZW-1:0] z_reg;
    logic [3:0]                  i_reg;
    logic                        mode_reg, degen_reg, qvalid_reg;
    logic [bom_pkg::SQ_W-1:0]    rem_reg, res_reg;
    logic [bom_pkg::SQ_W-2:0]    bit_reg;
    logic [5:0]                  qidx_reg;
    logic                        out_full_reg;
    logic [39:0]                 out_data_reg;
    logic [1:0]                  out_user_reg;

    // pixel arithmetic
    bom_pkg::acc_t       cur;
    logic signed [12:0]  dx, dy;
    logic signed [50:0]  cov_sum;
    logic [49:0]         vx_sum, vy_sum;
    logic [25:0]         dist_sum;
    bom_pkg::acc_t       acc_new;

    assign cur = acc_vld_reg[addr_reg] ? acc_rd_reg : '0;
    assign dx  = $signed({1'b0, px_reg}) - $signed({1'b0, ent_rd_reg.cx});
    assign dy  = $signed({1'b0, py_reg}) - $signed({1'b0, ent_rd_reg.cy});
    assign cov_sum = $signed({cur.cov[bom_pkg::COV_W-1], cur.cov}) + 51'(pxy_reg);
    assign vx_sum  = {1'b0, cur.vx} + {25'd0, pxx_reg[24:0]};
    assign vy_sum  = {1'b0, cur.vy} + {25'd0, pyy_reg[24:0]};
    assign dist_sum = {1'b0, pxx_reg[24:0]} + {1'b0, pyy_reg[24:0]};

    always_comb begin
        acc_new = cur;
        if (cov_sum[50] != cov_sum[49]) begin
            acc_new.cov = cov_sum[50] ? {1'b1, 49'd0} : {1'b0, {49{1'b1}}};
        end else begin
            acc_new.cov = cov_sum[49:0];
        end
        acc_new.vx = vx_sum[49] ? {49{1'b1}} : vx_sum[48:0];
        acc_new.vy = vy_sum[49] ? {49{1'b1}} : vy_sum[48:0];
        if (dist_sum > cur.maxd) begin
            acc_new.maxd = dist_sum;
        end
    end

    // cordic step
    logic signed [CW-1:0] xs, ys;
    logic                 norm_more;
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign norm_more = (x_reg < (CW'(1) <<< 47)) && (y_reg < (CW'(1) <<< 47))
                       && (y_reg > -(CW'(1) <<< 47));

    // sqrt step
    logic [bom_pkg::SQ_W-1:0] sq_trial;
    assign sq_trial = res_reg + {1'b0, bit_reg};

    // result assembly
    logic signed [bom_pkg::ZW-1:0] a_full, a_rnd;
    logic signed [15:0]            angle_val;
    logic [17:0]                   len_val;
    assign a_full = mode_reg ? (bom_pkg::HALF_PI_Q16 - z_reg) : z_reg;
    assign a_rnd  = (a_full + 20'sd4) >>> 3;
    always_comb begin
        if (!qvalid_reg) begin
            angle_val = '0;
        end else if (degen_reg) begin
            angle_val = bom_pkg::HALF_PI_Q13;
        end else begin
            angle_val = a_rnd[15:0];
        end
    end
    assign len_val = qvalid_reg ? (res_reg[17:0] + 18'(rem_reg > res_reg)) : '0;

    logic in_fire, out_load, bi_ok, lab_ok, pix_ok, idx_ok;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_QOUT) && (!out_full_reg || m_tready);
    assign bi_ok    = {1'b0, in_bi} < 7'(MAX_BLOBS);
    assign lab_ok   = {1'b0, in_label} < 7'(MAX_BLOBS);
    assign pix_ok   = ({1'b0, in_px} < 13'(MAX_WIDTH)) && ({1'b0, in_py} < 13'(MAX_HEIGHT));
    assign idx_ok   = {1'b0, ent_rd_reg.assign_idx} < 7'(MAX_BLOBS);

    always_comb begin
        state_next = state_reg;
        ent_we = 1'b0;
        ent_re = 1'b0;
        ent_wa = in_bi[AW-1:0];
        ent_ra = in_label[AW-1:0];
        ent_wd.assign_idx = in_assign;
        ent_wd.cx = in_cx;
        ent_wd.cy = in_cy;
        acc_we = 1'b0;
        acc_re = 1'b0;
        acc_ra = addr_reg;
        acc_wd = acc_new;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (in_cmd)
                        bom_pkg::CMD_LOAD: begin
                            ent_we = bi_ok;
                        end
                        bom_pkg::CMD_PIXEL: begin
                            if (in_lp && lab_ok && pix_ok) begin
                                ent_re = 1'b1;
                                state_next = ST_PENT;
                            end
                        end
                        bom_pkg::CMD_QUERY: begin
                            if (bi_ok && avail_reg[in_bi[AW-1:0]]) begin
                                acc_re = 1'b1;
                                acc_ra = in_bi[AW-1:0];
                                state_next = ST_QRD;
                            end else begin
                                state_next = ST_QOUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PENT: begin
                if (idx_ok) begin
                    ent_re = 1'b1;
                    ent_ra = ent_rd_reg.assign_idx[AW-1:0];
                    acc_re = 1'b1;
                    acc_ra = ent_rd_reg.assign_idx[AW-1:0];
                    state_next = ST_PCEN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PCEN:  state_next = ST_PMUL;
            ST_PMUL:  state_next = ST_PWB;
            ST_PWB: begin
                acc_we = 1'b1;
                state_next = ST_IDLE;
            end
            ST_QRD: begin
                if (cur.vx > cur.vy || cur.vy != '0) begin
                    state_next = ST_QNORM;
                end else begin
                    state_next = ST_QSQRT;
                end
            end
            ST_QNORM: begin
                if (!norm_more) begin
                    state_next = ST_QCORD;
                end
            end
            ST_QCORD: begin
                if (i_reg == 4'd15) begin
                    state_next = ST_QSQRT;
                end
            end
            ST_QSQRT: begin
                if (bit_reg == '0) begin
                    state_next = ST_QOUT;
                end
            end
            ST_QOUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            avail_reg    <= '0;
            acc_vld_reg  <= '0;
            out_full_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ent_we) begin
                avail_reg[in_bi[AW-1:0]]   <= in_avail;
                acc_vld_reg[in_bi[AW-1:0]] <= 1'b0;
            end
            if (acc_we) begin
                acc_vld_reg[addr_reg] <= 1'b1;
            end
            if (out_load) begin
                out_full_reg <= 1'b1;
            end else if (m_tready) begin
                out_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                px_reg     <= in_px;
                py_reg     <= in_py;
                qidx_reg   <= in_bi;
                addr_reg   <= in_bi[AW-1:0];
                qvalid_reg <= 1'b0;
                degen_reg  <= 1'b0;
            end
            ST_PENT: begin
                addr_reg <= ent_rd_reg.assign_idx[AW-1:0];
            end
            ST_PCEN: begin
                pxy_reg <= dx * dy;
                pxx_reg <= dx * dx;
                pyy_reg <= dy * dy;
            end
            ST_QRD: begin
                qvalid_reg <= 1'b1;
                y_reg      <= CW'($signed(cur.cov));
                z_reg      <= '0;
                i_reg      <= '0;
                rem_reg    <= {cur.maxd, 10'd0};
                res_reg    <= '0;
                bit_reg    <= {1'b1, 34'd0};
                if (cur.vx > cur.vy) begin
                    x_reg    <= CW'(cur.vx);
                    mode_reg <= 1'b0;
                end else begin
                    x_reg    <= CW'(cur.vy);
                    mode_reg <= 1'b1;
                    degen_reg <= (cur.vy == '0);
                end
            end
            ST_QNORM: begin
                if (norm_more) begin
                    x_reg <= x_reg <<< 1;
                    y_reg <= y_reg <<< 1;
                end
            end
            ST_QCORD: begin
                i_reg <= i_reg + 4'd1;
                if (y_reg < 0) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - bom_pkg::atan_q16(i_reg);
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + bom_pkg::atan_q16(i_reg);
                end
            end
            ST_QSQRT: begin
                if (bit_reg != '0) begin
                    if (rem_reg >= sq_trial) begin
                        rem_reg <= rem_reg - sq_trial;
                        res_reg <= (res_reg >> 1) + {1'b0, bit_reg};
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            out_data_reg <= {len_val, angle_val, qidx_reg};
            out_user_reg <= {degen_reg & qvalid_reg, qvalid_reg};
        end
    end

    assign m_tvalid = out_full_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire
